// ===== hdl/prcp_pkg.sv =====
// shared types and constants for the prefix reuse candidate picker
`default_nettype none

package prcp_pkg;

   localparam int LENGTH_BITS    = 20;
   localparam int MAX_CANDIDATES = 256;
   localparam int INDEX_BITS     = 8;
   localparam int INDEX_LIMIT    = (MAX_CANDIDATES < 256) ? MAX_CANDIDATES : 256;
   localparam int COUNT_SAT      = 256;
   localparam int COUNT_BITS     = 9;
   localparam int PRODUCT_BITS   = 2 * LENGTH_BITS;

   typedef logic [LENGTH_BITS-1:0] len_type;
   typedef logic [INDEX_BITS-1:0]  index_type;
   typedef logic [COUNT_BITS-1:0]  count_type;

   typedef enum logic {
      OP_BASELINE  = 1'b0,
      OP_CANDIDATE = 1'b1
   } op_type;

   typedef struct packed {
      op_type  op;
      len_type prefix_len;
      len_type prompt_len;
      logic    last;
   } req_type;

   typedef struct packed {
      logic      found;
      index_type best_index;
      len_type   best_prefix;
   } rsp_type;

   typedef struct packed {
      len_type   best_prefix;
      len_type   best_length;
      logic      keep_negative;
      index_type winner_index;
      logic      winner_valid;
      count_type candidate_count;
   } state_type;

   localparam state_type STATE_RESET = '{
      best_prefix:     '0,
      best_length:     '0,
      keep_negative:   1'b1,
      winner_index:    '0,
      winner_valid:    1'b0,
      candidate_count: '0
   };

endpackage

`default_nettype wire

// ===== hdl/prcp_if.sv =====
// valid/ready channel interfaces for transactions in and results out
`default_nettype none

interface prcp_req_if;
   logic              valid;
   logic              ready;
   prcp_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface prcp_rsp_if;
   logic              valid;
   logic              ready;
   prcp_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/prefix_reuse_candidate_picker.sv =====
// top level: input register, round state, result register
//
//  channel  | dir | handshake          | payload
//  req_chan | in  | valid/ready (sink) | op, prefix_len, prompt_len, last
//  rsp_chan | out | valid/ready (src)  | found, best_index, best_prefix
//
// one transaction per cycle while no last transaction waits on a stalled result; a
// result is registered after its last transaction is taken: it sits in the input
// register while the compare runs, then the result register loads. the loop through
// the two 20x20 cross products and the round state sets the cycle. synchronous reset
// clears the round state and both valid flags. a stalled result holds only a last
// transaction in the input register; other transactions keep flowing
`default_nettype none

module prefix_reuse_candidate_picker (
   input wire            clock,
   input wire            reset,
   prcp_req_if.sink      req_chan,
   prcp_rsp_if.source    rsp_chan
);

   logic                stage_valid_ff;
   logic                stage_valid_in;
   prcp_pkg::req_type   stage_ff;
   prcp_pkg::state_type state_ff;
   prcp_pkg::state_type state_in;
   prcp_pkg::rsp_type   result;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   prcp_pkg::rsp_type   rsp_payload_ff;
   logic                out_free;
   logic                stage_fire;
   logic                req_take;

   prcp_eval u_eval (
      .state_cur  (state_ff),
      .item       (stage_ff),
      .state_next (state_in),
      .result     (result)
   );

   always_comb begin
      out_free       = !rsp_valid_ff || rsp_chan.ready;
      stage_fire     = stage_valid_ff && (!stage_ff.last || out_free);
      req_chan.ready = !stage_valid_ff || stage_fire;
      req_take       = req_chan.valid && req_chan.ready;
      stage_valid_in = req_take || (stage_valid_ff && !stage_fire);
      if (stage_fire && stage_ff.last) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff       <= prcp_pkg::STATE_RESET;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (stage_fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_ff <= req_chan.payload;
      end
      if (stage_fire && stage_ff.last) begin
         rsp_payload_ff <= result;
      end
   end

   // a winner needs at least one counted candidate
   assert property (@(posedge clock) disable iff (reset)
      state_ff.winner_valid |-> (state_ff.candidate_count != '0))
      else $error("winner without any candidate");

   // a winner always has a real keep ratio
   assert property (@(posedge clock) disable iff (reset)
      state_ff.winner_valid |-> !state_ff.keep_negative)
      else $error("winner with negative keep ratio");

   // a closing transaction always produces a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      (stage_fire && stage_ff.last) |=> rsp_valid_ff)
      else $error("closing transaction lost its result");

   // a round closes back to the reset state
   assert property (@(posedge clock) disable iff (reset)
      (stage_fire && stage_ff.last) |=> (state_ff == prcp_pkg::STATE_RESET))
      else $error("round state not cleared after last");

endmodule

`default_nettype wire

// ===== hdl/prcp_eval.sv =====
// combinational round update: skip test, exact ratio compare, result and round clear
`default_nettype none

module prcp_eval (
   input  wire prcp_pkg::state_type state_cur,
   input  wire prcp_pkg::req_type   item,
   output prcp_pkg::state_type      state_next,
   output prcp_pkg::rsp_type        result
);

   prcp_pkg::state_type st;
   logic                      eligible;
   logic                      keep_gt;
   logic [prcp_pkg::PRODUCT_BITS-1:0] cand_cross;
   logic [prcp_pkg::PRODUCT_BITS-1:0] best_cross;

   // cross products for p / l > bp / bl
   assign cand_cross = item.prefix_len * state_cur.best_length;
   assign best_cross = state_cur.best_prefix * item.prompt_len;

   always_comb begin
      eligible = (state_cur.candidate_count < prcp_pkg::COUNT_BITS'(prcp_pkg::INDEX_LIMIT))
               && (item.prompt_len != '0)
               && !({item.prefix_len, 2'b00} < {2'b00, item.prompt_len});
      keep_gt  = state_cur.keep_negative || (state_cur.best_length == '0)
               || (cand_cross > best_cross);
   end

   always_comb begin
      st = state_cur;
      unique case (item.op)
         prcp_pkg::OP_BASELINE: begin
            st               = prcp_pkg::STATE_RESET;
            st.best_prefix   = item.prefix_len;
            st.best_length   = item.prompt_len;
            st.keep_negative = (item.prompt_len == '0);
         end
         prcp_pkg::OP_CANDIDATE: begin
            if (state_cur.candidate_count < prcp_pkg::COUNT_BITS'(prcp_pkg::COUNT_SAT)) begin
               st.candidate_count = state_cur.candidate_count + 1'b1;
            end
            if (eligible && keep_gt && (item.prefix_len > state_cur.best_prefix)) begin
               st.best_prefix   = item.prefix_len;
               st.best_length   = item.prompt_len;
               st.keep_negative = 1'b0;
               st.winner_index  = state_cur.candidate_count[prcp_pkg::INDEX_BITS-1:0];
               st.winner_valid  = 1'b1;
            end
         end
         default: st = state_cur;
      endcase

      result.found       = st.winner_valid;
      result.best_index  = st.winner_valid ? st.winner_index : '0;
      result.best_prefix = st.best_prefix;

      // the last transaction of a round closes it
      state_next = item.last ? prcp_pkg::STATE_RESET : st;
   end

endmodule

`default_nettype wire

// ===== dv/prefix_reuse_candidate_picker_test.sv =====
// testbench for the prefix reuse candidate picker: directed table, then random rounds
module prefix_reuse_candidate_picker_test;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int RANDOM_ITEMS    = 800;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 20;
   localparam prcp_pkg::len_type LEN_MAX = '1;

   typedef struct {
      prcp_pkg::req_type item;
      bit                typed;
      prcp_pkg::rsp_type want;
   } plan_row_type;

   logic clock;
   logic reset;

   prcp_req_if req_chan();
   prcp_rsp_if rsp_chan();

   prefix_reuse_candidate_picker dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predictor copy of the round state
   prcp_pkg::len_type   pick_prefix;
   prcp_pkg::len_type   pick_length;
   logic                pick_keep_neg;
   prcp_pkg::index_type pick_index;
   logic                pick_won;
   prcp_pkg::count_type pick_count;

   prcp_pkg::rsp_type pending_picks[$];
   plan_row_type      plan[$];

   int  mismatches;
   int  cycle_count;
   int  items_sent;
   int  results_seen;
   int  winners_seen;
   int  input_stalls;
   int  rounds_run;
   int  burst_left;
   bit  hold_off_req;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_picks.size());
         $display("prefix_reuse_candidate_picker_test failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
      mismatches++;
   endtask

   function automatic void clear_pick();
      pick_prefix   = '0;
      pick_length   = '0;
      pick_keep_neg = 1'b1;
      pick_index    = '0;
      pick_won      = 1'b0;
      pick_count    = '0;
   endfunction

   // advance the predicted round by one transaction
   task automatic pick_step(input prcp_pkg::req_type t, output bit emits,
                            output prcp_pkg::rsp_type r);
      logic [prcp_pkg::PRODUCT_BITS-1:0] cand_cross;
      logic [prcp_pkg::PRODUCT_BITS-1:0] best_cross;
      logic [prcp_pkg::LENGTH_BITS+1:0]  quad;
      prcp_pkg::count_type               idx;
      logic                              keep_up;
      emits = 1'b0;
      r     = '0;
      if (t.op == prcp_pkg::OP_BASELINE) begin
         clear_pick();
         pick_prefix   = t.prefix_len;
         pick_length   = t.prompt_len;
         pick_keep_neg = (t.prompt_len == 0);
      end else begin
         idx = pick_count;
         if (pick_count < prcp_pkg::COUNT_SAT)
            pick_count++;
         quad       = {t.prefix_len, 2'b00};
         // exact ratio compare: p / l > bp / bl
         cand_cross = t.prefix_len * pick_length;
         best_cross = pick_prefix * t.prompt_len;
         keep_up    = pick_keep_neg || pick_length == 0 || cand_cross > best_cross;
         if (idx < prcp_pkg::INDEX_LIMIT && t.prompt_len != 0 && quad >= t.prompt_len &&
             keep_up && t.prefix_len > pick_prefix) begin
            pick_prefix   = t.prefix_len;
            pick_length   = t.prompt_len;
            pick_keep_neg = 1'b0;
            pick_index    = idx[prcp_pkg::INDEX_BITS-1:0];
            pick_won      = 1'b1;
         end
      end
      if (t.last) begin
         emits         = 1'b1;
         r.found       = pick_won;
         r.best_index  = pick_won ? pick_index : '0;
         r.best_prefix = pick_prefix;
         clear_pick();
      end
   endtask

   function automatic prcp_pkg::req_type make_item(prcp_pkg::op_type op, prcp_pkg::len_type p,
                                                   prcp_pkg::len_type l, bit last);
      prcp_pkg::req_type t;
      t.op         = op;
      t.prefix_len = p;
      t.prompt_len = l;
      t.last       = last;
      return t;
   endfunction

   function automatic void add_row(prcp_pkg::op_type op, int prefix, int prompt, bit last,
                                   bit typed = 0, bit found = 0, int index = 0, int best = 0);
      plan_row_type row;
      row.item             = make_item(op, prcp_pkg::len_type'(prefix),
                                       prcp_pkg::len_type'(prompt), last);
      row.typed            = typed;
      row.want.found       = found;
      row.want.best_index  = prcp_pkg::index_type'(index);
      row.want.best_prefix = prcp_pkg::len_type'(best);
      plan = {plan, row};
   endfunction

   function automatic prcp_pkg::len_type rand_len(int scale);
      case (scale)
         0:       return prcp_pkg::len_type'($urandom_range(0, 15));
         1:       return prcp_pkg::len_type'($urandom_range(0, 1023));
         default: return prcp_pkg::len_type'($urandom() & 32'hFFFFF);
      endcase
   endfunction

   // candidate length: mostly within one to four times the prefix so it is not skipped
   function automatic prcp_pkg::len_type cand_len(prcp_pkg::len_type p, int scale);
      longint base;
      longint v;
      base = p;
      case ($urandom_range(0, 9))
         0:       return '0;
         1, 2:    return rand_len(scale);
         default: begin
            v = base + longint'($urandom_range(0, 32'(3 * base)));
            return (v > LEN_MAX) ? LEN_MAX : prcp_pkg::len_type'(v);
         end
      endcase
   endfunction

   // sender works in bursts; valid stays high from one transaction to the next
   task automatic send_item(input prcp_pkg::req_type t, input bit typed,
                            input prcp_pkg::rsp_type want);
      int                gap;
      bit                emits;
      prcp_pkg::rsp_type r;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= t;
      @(posedge clock);
      while (!req_chan.ready) begin
         input_stalls++;
         @(posedge clock);
      end
      pick_step(t, emits, r);
      if (emits)
         pending_picks = {pending_picks, (typed ? want : r)};
      items_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   // receiver: stretches of steady, random and sparse ready, plus long hold-offs on request
   initial begin
      int mode;
      int stretch_left;
      rsp_chan.ready = 1'b0;
      stretch_left   = 0;
      mode           = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            if (stretch_left == 0) begin
               mode         = $urandom_range(0, 2);
               stretch_left = $urandom_range(5, 40);
            end
            stretch_left--;
            case (mode)
               0:       rsp_chan.ready <= 1'b1;
               1:       rsp_chan.ready <= 1'($urandom_range(0, 1));
               default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      prcp_pkg::rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (pending_picks.size() == 0) begin
            report_mismatch("result with none expected, best_prefix",
                            rsp_chan.payload.best_prefix, 0);
         end else begin
            want = pending_picks.pop_front();
            if (rsp_chan.payload.found != want.found)
               report_mismatch("found", rsp_chan.payload.found, want.found);
            if (rsp_chan.payload.best_index != want.best_index)
               report_mismatch("best_index", rsp_chan.payload.best_index, want.best_index);
            if (rsp_chan.payload.best_prefix != want.best_prefix)
               report_mismatch("best_prefix", rsp_chan.payload.best_prefix, want.best_prefix);
            if (rsp_chan.payload.found)
               winners_seen++;
         end
      end
   end

   initial begin
      int                scale;
      int                n_cand;
      int                first_random;
      bit                lead;
      prcp_pkg::len_type p;
      prcp_pkg::len_type l;
      prcp_pkg::rsp_type none;

      none             = '0;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      hold_off_req     = 1'b0;
      burst_left       = 0;
      clear_pick();

      //       op                      prefix   prompt   last typed found idx best
      add_row(prcp_pkg::OP_BASELINE,  0,       0,       1,   1,    0,    0,  0);  // fresh from reset
      add_row(prcp_pkg::OP_BASELINE,  LEN_MAX, LEN_MAX, 1,   1,    0,    0,  LEN_MAX);  // baseline is last
      add_row(prcp_pkg::OP_CANDIDATE, 5,       10,      1,   1,    1,    0,  5);  // no baseline yet
      // empty slot prompt, zero-length and too-short candidates
      add_row(prcp_pkg::OP_BASELINE,  3,       0,       0);
      add_row(prcp_pkg::OP_CANDIDATE, 4,       16,      0);
      add_row(prcp_pkg::OP_CANDIDATE, 1,       0,       0);
      add_row(prcp_pkg::OP_CANDIDATE, 2,       9,       1,   1,    1,    0,  4);
      // lower ratio, equal ratio, then two winners, then a prefix tie
      add_row(prcp_pkg::OP_BASELINE,  10,      20,      0);
      add_row(prcp_pkg::OP_CANDIDATE, 12,      30,      0);
      add_row(prcp_pkg::OP_CANDIDATE, 15,      30,      0);
      add_row(prcp_pkg::OP_CANDIDATE, 16,      30,      0);
      add_row(prcp_pkg::OP_CANDIDATE, 17,      17,      0);
      add_row(prcp_pkg::OP_CANDIDATE, 17,      16,      1);
      // second baseline restarts the round
      add_row(prcp_pkg::OP_BASELINE,  1,       2,       0);
      add_row(prcp_pkg::OP_CANDIDATE, 100,     100,     0);
      add_row(prcp_pkg::OP_BASELINE,  50,      50,      0);
      add_row(prcp_pkg::OP_CANDIDATE, 40,      40,      1);
      // full-scale lengths
      add_row(prcp_pkg::OP_BASELINE,  0,       LEN_MAX, 0);
      add_row(prcp_pkg::OP_CANDIDATE, LEN_MAX, LEN_MAX, 1,   1,    1,    0,  LEN_MAX);
      add_row(prcp_pkg::OP_BASELINE,  LEN_MAX, 1,       0);
      add_row(prcp_pkg::OP_CANDIDATE, LEN_MAX, LEN_MAX, 1,   1,    0,    0,  LEN_MAX);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i])
         send_item(plan[i].item, plan[i].typed, plan[i].want);

      first_random = items_sent;
      hold_off_req = 1'b1;
      while (items_sent - first_random < RANDOM_ITEMS) begin
         rounds_run++;
         if (rounds_run == 40)
            hold_off_req = 1'b1;
         if (rounds_run == 20) begin
            // every candidate wins until the index limit, none after it
            n_cand = $urandom_range(257, 300);
            send_item(make_item(prcp_pkg::OP_BASELINE, '0, rand_len(0), 1'b0), 1'b0, none);
            for (int k = 0; k < n_cand; k++)
               send_item(make_item(prcp_pkg::OP_CANDIDATE, prcp_pkg::len_type'(k + 1),
                                   prcp_pkg::len_type'(k + 2), k == n_cand - 1),
                         1'b0, none);
         end else begin
            scale  = $urandom_range(0, 19);
            scale  = (scale < 10) ? 0 : (scale < 17) ? 1 : 2;
            n_cand = $urandom_range(0, 10);
            lead   = ($urandom_range(0, 19) != 0);
            if (!lead && n_cand == 0)
               n_cand = 1;
            if (lead) begin
               p = rand_len(scale);
               l = ($urandom_range(0, 9) == 0) ? prcp_pkg::len_type'(0) : rand_len(scale);
               send_item(make_item(prcp_pkg::OP_BASELINE, p, l, n_cand == 0), 1'b0, none);
            end
            for (int k = 0; k < n_cand; k++) begin
               if ($urandom_range(0, 39) == 0)
                  send_item(make_item(prcp_pkg::OP_BASELINE, rand_len(scale),
                                      rand_len(scale), 1'b0),
                            1'b0, none);
               p = rand_len(scale);
               l = cand_len(p, scale);
               send_item(make_item(prcp_pkg::OP_CANDIDATE, p, l, k == n_cand - 1), 1'b0, none);
            end
         end
      end
      req_chan.valid <= 1'b0;

      while (pending_picks.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d transactions: the directed table and %0d random rounds",
               items_sent, rounds_run);
      $display("checked %0d results, %0d with a winner; input stalled on %0d cycles",
               results_seen, winners_seen, input_stalls);
      if (mismatches == 0)
         $display("prefix_reuse_candidate_picker_test passed");
      else
         $display("prefix_reuse_candidate_picker_test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/prcp_pkg.sv
hdl/prcp_if.sv
hdl/prcp_eval.sv
hdl/prefix_reuse_candidate_picker.sv
dv/prefix_reuse_candidate_picker_test.sv
